// File: src/mmt_pkg.sv
package mmt_pkg;

  // Command codes carried in the command field.
  localparam logic [2:0] CMD_WAKE  = 3'd0;
  localparam logic [2:0] CMD_SLEEP = 3'd1;
  localparam logic [2:0] CMD_MOVE  = 3'd2;
  localparam logic [2:0] CMD_HOME  = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_QUERY = 3'd5;

  // Configuration register word indexes.
  localparam logic [1:0] REG_MOTOR_COUNT = 2'd0;
  localparam logic [3:0] MOTOR_COUNT_RESET = 4'd8;

  // Duration arithmetic: distance up to 2^32, times 1000, plus speed minus one.
  localparam int DIST_W = 33;
  localparam int NUM_W  = 43;
  localparam int SPD_W  = 16;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         motor_mask;
    logic signed [31:0] target_position;
    logic [15:0]        move_speed;
    logic [15:0]        move_accel;
    logic signed [31:0] overshoot_steps;
    logic signed [31:0] backoff_steps;
    logic [31:0]        now_ms;
  } mmt_in_t;

  typedef struct packed {
    logic       accepted;
    logic       any_moving;
    logic [7:0] moving_flags;
    logic [7:0] awake_flags;
  } mmt_out_t;

  // One memory entry per motor.
  typedef struct packed {
    logic [31:0] position;
    logic [31:0] plan_target;
    logic [31:0] plan_end_time;
  } mmt_entry_t;

endpackage

// File: src/mmt_div.sv
module mmt_div
  import mmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SPD_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SPD_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [SPD_W-1:0] den_r;
  logic [SPD_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? SPD_W'(trial - {1'b0, den_r}) : trial[SPD_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/multi_motor_move_timer.sv
// Multi-motor move timer.
// Input channel (in_valid, in_stall, in_data) takes one command transaction:
// wake, sleep, move absolute, home, tick or query on the motors in the mask.
// Result channel (out_valid, out_stall, out_data) gives one result per
// command: accepted, the query answer and the moving and awake flags of
// the first eight motors after the command.
// Wake, sleep, query, unused codes and rejected commands go from the start
// state through the done state to the result register. Tick reads each
// motor with an active plan. An accepted move or home, per selected motor,
// reads memory, forms the numerator, runs the divider and writes back: the
// per-motor duration ceil(1000*distance/speed) runs on one shared divider
// that makes one quotient bit per cycle over 43 bits. One command is in
// work at a time; a new one is taken as soon as the previous result sits in
// the output register, even while the receiver still stalls it.
// Per-motor position, target and end time live in a one-port memory with a
// registered read; flags live in flip-flops. Reset clears the
// flags and sets the motor count to 8; positions read as zero until first
// written, so no clearing pass is needed.
// The APB port holds motor_count; the write decode matches every address.
module multi_motor_move_timer
  import mmt_pkg::*;
#(
  parameter int MAX_MOTORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  mmt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output mmt_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
  localparam int CW = $clog2(MAX_MOTORS + 1);
  localparam int FW = (MAX_MOTORS < 8) ? MAX_MOTORS : 8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_RDW   = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_DIVS  = 4'd5;
  localparam logic [3:0] ST_DIVW  = 4'd6;
  localparam logic [3:0] ST_WB    = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]            state_r, state_nxt;
  mmt_in_t               item_r;
  logic [3:0]            count_r;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [MAX_MOTORS-1:0] moving_r, moving_nxt;
  logic [MAX_MOTORS-1:0] awake_r, awake_nxt;
  logic [MAX_MOTORS-1:0] plan_r, plan_nxt;
  logic [MAX_MOTORS-1:0] pos_ok_r, pos_ok_nxt;
  logic                  acc_r, acc_nxt;
  logic                  anym_r, anym_nxt;
  logic                  out_valid_r;
  mmt_out_t              out_r;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic [NUM_W-1:0]      num_r;
  logic [SPD_W-1:0]      den_r;

  mmt_entry_t            mem [MAX_MOTORS];
  mmt_entry_t            rd_r;
  logic                  mem_re, mem_we;
  mmt_entry_t            wr_data;

  logic [CW-1:0]         used;
  logic [MAX_MOTORS-1:0] sel;
  logic                  busy_sel;
  logic [IW-1:0]         addr;
  logic                  is_move_cmd;
  logic                  div_done;
  logic [NUM_W-1:0]      div_q;
  logic [31:0]           dur;
  logic [31:0]           pos_eff;
  logic [DIST_W-1:0]     diff, over_mag, back_mag;
  logic [7:0]            mf, af;

  // Configuration port: one register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {28'd0, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= MOTOR_COUNT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[1:0] >> 2) == REG_MOTOR_COUNT) begin
      count_r <= cfg_pwdata[3:0];
    end
  end

  // Motors in use and the selection of the current command.
  assign used = ({28'd0, count_r} > MAX_MOTORS) ? CW'(MAX_MOTORS) : CW'(count_r);

  always_comb begin
    sel = '0;
    for (int i = 0; i < FW; i++) begin
      sel[i] = item_r.motor_mask[i[2:0]] && (CW'(i) < used);
    end
  end

  assign busy_sel    = |(sel & moving_r);
  assign addr        = idx_r[IW-1:0];
  assign is_move_cmd = (item_r.command == CMD_MOVE);

  // Distance terms for the motor just read.
  assign pos_eff  = pos_ok_r[addr] ? rd_r.position : 32'd0;
  assign diff     = {item_r.target_position[31], item_r.target_position} -
                    {pos_eff[31], pos_eff};
  assign over_mag = item_r.overshoot_steps[31] ?
                    DIST_W'(-{item_r.overshoot_steps[31], item_r.overshoot_steps}) :
                    DIST_W'({1'b0, item_r.overshoot_steps});
  assign back_mag = item_r.backoff_steps[31] ?
                    DIST_W'(-{item_r.backoff_steps[31], item_r.backoff_steps}) :
                    DIST_W'({1'b0, item_r.backoff_steps});

  // Saturated duration from the divider.
  assign dur = (|div_q[NUM_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];

  mmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIVS),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // Command sequencer.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    moving_nxt = moving_r;
    awake_nxt  = awake_r;
    plan_nxt   = plan_r;
    pos_ok_nxt = pos_ok_r;
    acc_nxt    = acc_r;
    anym_nxt   = anym_r;
    dist_nxt   = dist_r;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    wr_data    = rd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        acc_nxt   = 1'b1;
        anym_nxt  = 1'b0;
        idx_nxt   = '0;
        state_nxt = ST_DONE;
        case (item_r.command)
          CMD_WAKE: begin
            awake_nxt = awake_r | sel;
          end
          CMD_SLEEP: begin
            if (busy_sel) begin
              acc_nxt = 1'b0;
            end else begin
              awake_nxt = awake_r & ~sel;
            end
          end
          CMD_MOVE, CMD_HOME: begin
            if (busy_sel) begin
              acc_nxt = 1'b0;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          CMD_TICK: begin
            state_nxt = ST_SCAN;
          end
          CMD_QUERY: begin
            anym_nxt = busy_sel;
          end
          default: begin
            acc_nxt = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        if (idx_r == CW'(MAX_MOTORS)) begin
          state_nxt = ST_DONE;
        end else if ((item_r.command == CMD_TICK) ? (plan_r[addr] && idx_r < used)
                                                  : sel[addr]) begin
          mem_re    = 1'b1;
          state_nxt = ST_RDW;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RDW: begin
        if (item_r.command == CMD_TICK) begin
          if (item_r.now_ms >= rd_r.plan_end_time) begin
            mem_we             = 1'b1;
            wr_data.position   = rd_r.plan_target;
            pos_ok_nxt[addr]   = 1'b1;
            moving_nxt[addr]   = 1'b0;
            awake_nxt[addr]    = 1'b0;
            plan_nxt[addr]     = 1'b0;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          if (is_move_cmd) begin
            dist_nxt = diff[DIST_W-1] ? DIST_W'(-diff) : diff;
          end else begin
            dist_nxt = over_mag + back_mag;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        mem_we                = 1'b1;
        wr_data.position      = pos_eff;
        wr_data.plan_target   = is_move_cmd ? item_r.target_position : 32'd0;
        wr_data.plan_end_time = item_r.now_ms + dur;
        pos_ok_nxt[addr]      = 1'b1;
        moving_nxt[addr]      = 1'b1;
        awake_nxt[addr]       = 1'b1;
        plan_nxt[addr]        = 1'b1;
        idx_nxt               = idx_r + 1'b1;
        state_nxt             = ST_SCAN;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      moving_r <= '0;
      awake_r  <= '0;
      plan_r   <= '0;
      pos_ok_r <= '0;
      acc_r    <= 1'b0;
      anym_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      moving_r <= moving_nxt;
      awake_r  <= awake_nxt;
      plan_r   <= plan_nxt;
      pos_ok_r <= pos_ok_nxt;
      acc_r    <= acc_nxt;
      anym_r   <= anym_nxt;
    end
  end

  // Item capture and the duration numerator.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    dist_r <= dist_nxt;
    if (state_r == ST_MUL) begin
      num_r <= NUM_W'(dist_r) * NUM_W'(MS_PER_S) + NUM_W'(den_r) - NUM_W'(1);
    end
    if (state_r == ST_RDW) begin
      den_r <= (item_r.move_speed == '0) ? SPD_W'(1) : item_r.move_speed;
    end
  end

  // Per-motor memory, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wr_data;
    end
    if (mem_re) begin
      rd_r <= mem[addr];
    end
  end

  // Reported flags of the first eight motors.
  always_comb begin
    mf = '0;
    af = '0;
    for (int j = 0; j < FW; j++) begin
      mf[j] = moving_r[j];
      af[j] = awake_r[j];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_r.accepted     <= acc_r;
      out_r.any_moving   <= anym_r;
      out_r.moving_flags <= mf;
      out_r.awake_flags  <= af;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result is loaded only from the completion state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result appeared without a finished command");

  // Flags never change while no command is in work.
  a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |=> $stable(moving_r) && $stable(awake_r))
    else $error("motor flags changed while idle");

  // The memory is written only by a command in work.
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_RDW || state_r == ST_WB))
    else $error("memory write outside a command");

  // Divider results are consumed only while waiting for them.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVW)
    else $error("divider finished outside its wait state");

endmodule

// File: tb/multi_motor_move_timer_checker.sv
`timescale 1ns / 1ps

module multi_motor_move_timer_checker
  import mmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  mmt_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  mmt_out_t out_data,
  input  logic     cfg_psel,
  input  logic     cfg_penable,
  input  logic     cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int       fail_count,
  output int       pending_count,
  output int       result_count
);

  // Shadow copy of the motor state.
  logic [3:0]  motor_count;
  logic [31:0] position [8];
  logic [15:0] speed_set [8];
  logic [15:0] accel_set [8];
  logic [7:0]  moving;
  logic [7:0]  awake;
  logic [7:0]  plan_active;
  logic [31:0] plan_target [8];
  logic [31:0] plan_end [8];

  mmt_out_t expected_results[$];

  // Exact ceiling of 1000*distance/speed, saturated to 32 bits.
  function automatic logic [31:0] move_duration(logic [32:0] distance, logic [15:0] speed);
    logic [63:0] s;
    logic [63:0] q;
    s = (speed == 16'd0) ? 64'd1 : {48'd0, speed};
    q = ({31'd0, distance} * 64'd1000 + s - 64'd1) / s;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [32:0] magnitude(logic signed [32:0] v);
    return v[32] ? -v : v;
  endfunction

  // Apply one command to the shadow state and return its result.
  function automatic mmt_out_t run_command(mmt_in_t c);
    mmt_out_t r;
    logic [7:0] sel;
    logic [32:0] distance;
    logic [32:0] home_dist;
    int limit;
    limit = (motor_count > 8) ? 8 : motor_count;
    sel = 8'd0;
    for (int i = 0; i < limit; i++) sel[i] = c.motor_mask[i];
    r = '0;
    home_dist = magnitude({c.overshoot_steps[31], c.overshoot_steps}) +
                magnitude({c.backoff_steps[31], c.backoff_steps});
    case (c.command)
      CMD_WAKE: begin
        awake |= sel;
        r.accepted = 1'b1;
      end
      CMD_SLEEP: begin
        if ((sel & moving) == 8'd0) begin
          awake &= ~sel;
          r.accepted = 1'b1;
        end
      end
      CMD_MOVE, CMD_HOME: begin
        if ((sel & moving) == 8'd0) begin
          for (int i = 0; i < 8; i++) begin
            if (sel[i]) begin
              awake[i] = 1'b1;
              moving[i] = 1'b1;
              plan_active[i] = 1'b1;
              speed_set[i] = c.move_speed;
              accel_set[i] = c.move_accel;
              if (c.command == CMD_MOVE) begin
                distance = magnitude($signed({c.target_position[31], c.target_position}) -
                                     $signed({position[i][31], position[i]}));
                plan_target[i] = c.target_position;
              end else begin
                distance = home_dist;
                plan_target[i] = 32'd0;
              end
              plan_end[i] = c.now_ms + move_duration(distance, c.move_speed);
            end
          end
          r.accepted = 1'b1;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < limit; i++) begin
          if (plan_active[i] && c.now_ms >= plan_end[i]) begin
            position[i] = plan_target[i];
            moving[i] = 1'b0;
            awake[i] = 1'b0;
            plan_active[i] = 1'b0;
          end
        end
        r.accepted = 1'b1;
      end
      CMD_QUERY: begin
        r.any_moving = |(sel & moving);
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    r.moving_flags = moving;
    r.awake_flags = awake;
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Track configuration writes and input transactions, then check results.
  always @(posedge clk) begin
    mmt_out_t exp_r;
    if (!rst_n) begin
      motor_count <= MOTOR_COUNT_RESET;
      moving = '0;
      awake = '0;
      plan_active = '0;
      for (int i = 0; i < 8; i++) begin
        position[i] = '0;
        speed_set[i] = 16'd4000;
        accel_set[i] = 16'd16000;
        plan_target[i] = '0;
        plan_end[i] = '0;
      end
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_MOTOR_COUNT)
        motor_count <= cfg_pwdata[3:0];
      if (in_valid && !in_stall)
        expected_results.push_back(run_command(in_data));
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_data) begin
            $display({"%0t: result mismatch: expected acc=%b any=%b mov=%h awk=%h,",
                      " got acc=%b any=%b mov=%h awk=%h"},
                     $time, exp_r.accepted, exp_r.any_moving, exp_r.moving_flags,
                     exp_r.awake_flags, out_data.accepted, out_data.any_moving,
                     out_data.moving_flags, out_data.awake_flags);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/multi_motor_move_timer_tb.sv
`timescale 1ns / 1ps

module multi_motor_move_timer_tb;
  import mmt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  mmt_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  mmt_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending_count;
  int result_count;
  int cycle_count;
  int hold_cycles;
  logic stall_random;
  int sent_count;
  logic [31:0] clock_ms;

  multi_motor_move_timer DUT (.*);

  multi_motor_move_timer_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("** multi_motor_move_timer: FAILED **");
        $finish;
      end
    end
  end

  // Receiver stall: random gaps, occasional long hold-offs, and one on request.
  initial begin
    out_stall = 1'b0;
    hold_cycles = 0;
    stall_random = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (!stall_random) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 19) == 0) hold_cycles = $urandom_range(20, 120);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register write on the APB port: a setup phase, then an access phase.
  task automatic write_motor_count(logic [3:0] count);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MOTOR_COUNT;
    cfg_pwdata <= {28'd0, count};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Offer one command after a random gap and hold it until it is taken.
  // Valid stays high after acceptance so that a back-to-back command
  // replaces it without a second update in the same time step.
  task automatic send_command(mmt_in_t c, logic gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Random command, mostly well-formed move/tick flows with near-term times.
  function automatic mmt_in_t random_command();
    mmt_in_t c;
    int pick;
    c.target_position = random_word();
    c.overshoot_steps = random_word();
    c.backoff_steps = random_word();
    c.move_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    if ($urandom_range(0, 9) == 0) c.move_speed = 16'hFFFF;
    c.move_accel = 16'($urandom);
    c.motor_mask = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
    c.now_ms = ($urandom_range(0, 15) == 0) ? $urandom : clock_ms + $urandom_range(0, 3000);
    pick = $urandom_range(0, 99);
    if (pick < 10) c.command = CMD_WAKE;
    else if (pick < 18) c.command = CMD_SLEEP;
    else if (pick < 40) c.command = CMD_MOVE;
    else if (pick < 50) c.command = CMD_HOME;
    else if (pick < 80) c.command = CMD_TICK;
    else if (pick < 94) c.command = CMD_QUERY;
    else c.command = 3'($urandom_range(6, 7));
    if (c.command == CMD_TICK && $urandom_range(0, 4) == 0) c.now_ms = 32'hFFFF_FFFF;
    clock_ms = clock_ms + $urandom_range(0, 400);
    return c;
  endfunction

  function automatic mmt_in_t make_command(logic [2:0] cmd, logic [7:0] mask,
                                           logic [31:0] tgt, logic [15:0] spd,
                                           logic [31:0] now);
    mmt_in_t c;
    c = '0;
    c.command = cmd;
    c.motor_mask = mask;
    c.target_position = tgt;
    c.move_speed = spd;
    c.move_accel = 16'hFFFF;
    c.overshoot_steps = 32'h8000_0000;
    c.backoff_steps = 32'h7FFF_FFFF;
    c.now_ms = now;
    return c;
  endfunction

  // Stimulus.
  initial begin
    logic [3:0] counts [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    sent_count = 0;
    clock_ms = '0;
    counts = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every command, busy rejection, saturation, unused codes.
    send_command(make_command(CMD_QUERY, 8'hFF, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_WAKE, 8'hA5, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_SLEEP, 8'h05, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_MOVE, 8'h01, 32'h7FFF_FFFF, 16'd0, 32'hFFFF_FFF0), 1'b0);
    send_command(make_command(CMD_MOVE, 8'h03, 32'h8000_0000, 16'hFFFF, 32'd5), 1'b0);
    send_command(make_command(CMD_SLEEP, 8'h01, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_QUERY, 8'h01, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_HOME, 8'h80, 32'd0, 16'd1, 32'd100), 1'b0);
    send_command(make_command(CMD_HOME, 8'h40, 32'd0, 16'hFFFF, 32'd100), 1'b0);
    send_command(make_command(CMD_MOVE, 8'h20, 32'd0, 16'd7, 32'd9), 1'b0);
    send_command(make_command(CMD_TICK, 8'h00, 32'd0, 16'd0, 32'd9), 1'b0);
    send_command(make_command(CMD_TICK, 8'h00, 32'd0, 16'd0, 32'hFFFF_FFFF), 1'b0);
    send_command(make_command(3'd6, 8'hFF, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(3'd7, 8'hFF, 32'd0, 16'd0, 32'd0), 1'b0);
    send_command(make_command(CMD_MOVE, 8'h10, 32'hFFFF_FFFF, 16'd3, 32'hFFFF_FFFF), 1'b0);
    send_command(make_command(CMD_QUERY, 8'hFF, 32'd0, 16'd0, 32'd0), 1'b0);
    drain_results();

    // Random phases across several motor counts, extremes included.
    for (int p = 0; p < 5; p++) begin
      write_motor_count(counts[p]);
      for (int n = 0; n < 230; n++) begin
        send_command(random_command(), 1'b1);
        if (p == 1 && n == 100) drain_results();
      end
      if (p == 2) begin
        // Long receiver hold-off while commands keep coming.
        hold_cycles = 400;
        for (int n = 0; n < 6; n++) send_command(random_command(), 1'b0);
      end
      drain_results();
      if (p == 3) begin
        stall_random = 1'b0;
        for (int n = 0; n < 20; n++) send_command(random_command(), 1'b0);
        drain_results();
        stall_random = 1'b1;
      end
    end

    $display("Ran %0d commands over motor counts 8, 0, 15, 3 and 1; %0d results checked.",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("** multi_motor_move_timer: PASSED **");
    end else begin
      $display("** multi_motor_move_timer: FAILED **");
    end
    $finish;
  end

endmodule
